/* hw/rtl/qrs_pkg.sv */
// Shared widths, codes and types of the quadratic root solver.
package qrs_pkg;

    localparam int COEF_WIDTH     = 32;
    localparam int FRAC_BITS      = 16;

    // b*b - 4ac in magnitude form, padded to an even width for the root
    localparam int DISC_WIDTH     = 2 * COEF_WIDTH + 2;
    localparam int SQRT_STAGES    = DISC_WIDTH / 2;
    localparam int ROOT_WIDTH     = COEF_WIDTH + 1;
    localparam int SQRT_REM_WIDTH = COEF_WIDTH + 4;

    // numerator -b +/- sqrt(d): signed form and magnitude
    localparam int NUMS_WIDTH     = COEF_WIDTH + 3;
    localparam int NUM_WIDTH      = COEF_WIDTH + 2;
    localparam int QUO_WIDTH      = NUM_WIDTH + FRAC_BITS;
    localparam int DIV_REM_WIDTH  = COEF_WIDTH + 1;

    localparam int LANES          = 2;
    localparam int LANE_PLUS      = 0;
    localparam int LANE_MINUS     = 1;

    localparam logic [COEF_WIDTH-1:0] ROOT_MAX = {1'b0, {(COEF_WIDTH-1){1'b1}}};
    localparam logic [COEF_WIDTH-1:0] ROOT_MIN = {1'b1, {(COEF_WIDTH-1){1'b0}}};

    typedef enum logic [1:0] {
        KIND_NOT_QUAD = 2'd0,
        KIND_NO_REAL  = 2'd1,
        KIND_DOUBLE   = 2'd2,
        KIND_TWO      = 2'd3
    } kind_t;

    typedef struct packed {
        kind_t                  kind;
        logic                   aneg;
        logic [COEF_WIDTH-1:0]  amag;
        logic signed [COEF_WIDTH:0] negb;
    } ctx_t;

endpackage

/* hw/rtl/qrs_disc.sv */
// Coefficient decode, products and discriminant classification (three stages).
module qrs_disc (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   en,
    input  logic                                   in_valid,
    input  logic signed [qrs_pkg::COEF_WIDTH-1:0]  coef_a,
    input  logic signed [qrs_pkg::COEF_WIDTH-1:0]  coef_b,
    input  logic signed [qrs_pkg::COEF_WIDTH-1:0]  coef_c,
    output logic                                   valid,
    output qrs_pkg::ctx_t                          ctx,
    output logic [qrs_pkg::DISC_WIDTH-1:0]         disc
);
    import qrs_pkg::*;

    localparam int PW = 2 * COEF_WIDTH;

    logic [COEF_WIDTH-1:0] a_mag, b_mag, c_mag;

    logic                  v1_reg, v2_reg, v3_reg;
    logic                  an1_reg, bn1_reg, cn1_reg;
    logic [COEF_WIDTH-1:0] am1_reg, bm1_reg, cm1_reg;
    logic                  an2_reg, bn2_reg, cn2_reg, cz2_reg;
    logic [COEF_WIDTH-1:0] am2_reg, bm2_reg;
    logic [PW-1:0]         b2_reg, ac_reg;
    logic [PW-1:0]         b2_next, ac_next;
    ctx_t                  ctx_reg, ctx_next;
    logic [DISC_WIDTH-1:0] disc_reg, disc_next;
    logic [DISC_WIDTH-1:0] b2_ext, ac4;

    assign a_mag = coef_a[COEF_WIDTH-1] ? COEF_WIDTH'(-coef_a) : COEF_WIDTH'(coef_a);
    assign b_mag = coef_b[COEF_WIDTH-1] ? COEF_WIDTH'(-coef_b) : COEF_WIDTH'(coef_b);
    assign c_mag = coef_c[COEF_WIDTH-1] ? COEF_WIDTH'(-coef_c) : COEF_WIDTH'(coef_c);

    assign b2_next = PW'(bm1_reg) * PW'(bm1_reg);
    assign ac_next = PW'(am1_reg) * PW'(cm1_reg);

    assign b2_ext = DISC_WIDTH'(b2_reg);
    assign ac4    = {ac_reg, 2'b00};

    // classify the discriminant; opposite signs of a and c always give two roots
    always_comb
    begin
        ctx_next.aneg = an2_reg;
        ctx_next.amag = am2_reg;
        ctx_next.negb = bn2_reg ? $signed({1'b0, bm2_reg}) : -$signed({1'b0, bm2_reg});
        ctx_next.kind = KIND_NOT_QUAD;
        disc_next     = '0;
        if (am2_reg != '0)
        begin
            if (an2_reg != cn2_reg && !cz2_reg)
            begin
                ctx_next.kind = KIND_TWO;
                disc_next     = b2_ext + ac4;
            end
            else if (b2_ext < ac4)
            begin
                ctx_next.kind = KIND_NO_REAL;
            end
            else if (b2_ext == ac4)
            begin
                ctx_next.kind = KIND_DOUBLE;
            end
            else
            begin
                ctx_next.kind = KIND_TWO;
                disc_next     = b2_ext - ac4;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else if (en)
        begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            an1_reg  <= coef_a[COEF_WIDTH-1];
            bn1_reg  <= coef_b[COEF_WIDTH-1];
            cn1_reg  <= coef_c[COEF_WIDTH-1];
            am1_reg  <= a_mag;
            bm1_reg  <= b_mag;
            cm1_reg  <= c_mag;
            an2_reg  <= an1_reg;
            bn2_reg  <= bn1_reg;
            cn2_reg  <= cn1_reg;
            cz2_reg  <= (cm1_reg == '0);
            am2_reg  <= am1_reg;
            bm2_reg  <= bm1_reg;
            b2_reg   <= b2_next;
            ac_reg   <= ac_next;
            ctx_reg  <= ctx_next;
            disc_reg <= disc_next;
        end
    end

    assign valid = v3_reg;
    assign ctx   = ctx_reg;
    assign disc  = disc_reg;

endmodule

/* hw/rtl/qrs_sqrt.sv */
// Pipelined integer square root, two radicand bits per stage.
module qrs_sqrt (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            en,
    input  logic                            in_valid,
    input  qrs_pkg::ctx_t                   ctx_in,
    input  logic [qrs_pkg::DISC_WIDTH-1:0]  disc_in,
    output logic                            valid,
    output qrs_pkg::ctx_t                   ctx,
    output logic [qrs_pkg::ROOT_WIDTH-1:0]  root
);
    import qrs_pkg::*;

    logic                      v_reg    [SQRT_STAGES];
    ctx_t                      ctx_reg  [SQRT_STAGES];
    logic [DISC_WIDTH-1:0]     rad_reg  [SQRT_STAGES];
    logic [SQRT_REM_WIDTH-1:0] rem_reg  [SQRT_STAGES];
    logic [ROOT_WIDTH-1:0]     root_reg [SQRT_STAGES];

    for (genvar k = 0; k < SQRT_STAGES; k++)
    begin : g_stage
        logic                      v_prev;
        ctx_t                      c_prev;
        logic [DISC_WIDTH-1:0]     rad_prev;
        logic [SQRT_REM_WIDTH-1:0] rem_prev, rem_sh, trial;
        logic [ROOT_WIDTH-1:0]     root_prev;
        logic                      ge;

        if (k == 0)
        begin : g_first
            assign v_prev    = in_valid;
            assign c_prev    = ctx_in;
            assign rad_prev  = disc_in;
            assign rem_prev  = '0;
            assign root_prev = '0;
        end
        else
        begin : g_next
            assign v_prev    = v_reg[k-1];
            assign c_prev    = ctx_reg[k-1];
            assign rad_prev  = rad_reg[k-1];
            assign rem_prev  = rem_reg[k-1];
            assign root_prev = root_reg[k-1];
        end

        // bring down two radicand bits, try root*4+1
        assign rem_sh = {rem_prev[SQRT_REM_WIDTH-3:0], rad_prev[DISC_WIDTH-1 -: 2]};
        assign trial  = SQRT_REM_WIDTH'({root_prev, 2'b01});
        assign ge     = (rem_sh >= trial);

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                v_reg[k] <= 1'b0;
            else if (en)
                v_reg[k] <= v_prev;
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                ctx_reg[k]  <= c_prev;
                rad_reg[k]  <= rad_prev << 2;
                rem_reg[k]  <= ge ? (rem_sh - trial) : rem_sh;
                root_reg[k] <= {root_prev[ROOT_WIDTH-2:0], ge};
            end
        end
    end

    assign valid = v_reg[SQRT_STAGES-1];
    assign ctx   = ctx_reg[SQRT_STAGES-1];
    assign root  = root_reg[SQRT_STAGES-1];

endmodule

/* hw/rtl/qrs_div.sv */
// Numerator forming and two-lane pipelined restoring division, one quotient bit per stage.
module qrs_div (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            en,
    input  logic                            in_valid,
    input  qrs_pkg::ctx_t                   ctx_in,
    input  logic [qrs_pkg::ROOT_WIDTH-1:0]  root_in,
    output logic                            valid,
    output qrs_pkg::ctx_t                   ctx,
    output logic                            qneg [qrs_pkg::LANES],
    output logic [qrs_pkg::QUO_WIDTH-1:0]   quo  [qrs_pkg::LANES]
);
    import qrs_pkg::*;

    logic                     nv_reg;
    ctx_t                     nctx_reg;
    logic [QUO_WIDTH-1:0]     nnum_reg  [LANES];
    logic                     nqneg_reg [LANES];

    logic                     v_reg    [QUO_WIDTH];
    ctx_t                     ctx_reg  [QUO_WIDTH];
    logic [QUO_WIDTH-1:0]     num_reg  [LANES][QUO_WIDTH];
    logic [DIV_REM_WIDTH-1:0] rem_reg  [LANES][QUO_WIDTH];
    logic [QUO_WIDTH-1:0]     quo_reg  [LANES][QUO_WIDTH];
    logic                     qneg_reg [LANES][QUO_WIDTH];

    // numerator stage: -b + root for the plus lane, -b - root for the minus lane
    for (genvar l = 0; l < LANES; l++)
    begin : g_num
        logic signed [NUMS_WIDTH-1:0] nb, sr, n;
        logic [NUM_WIDTH-1:0]         nmag;

        assign nb   = NUMS_WIDTH'(ctx_in.negb);
        assign sr   = $signed(NUMS_WIDTH'(root_in));
        assign n    = (l == LANE_PLUS) ? (nb + sr) : (nb - sr);
        assign nmag = n[NUMS_WIDTH-1] ? NUM_WIDTH'(-n) : NUM_WIDTH'(n);

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                nnum_reg[l]  <= QUO_WIDTH'(nmag) << FRAC_BITS;
                nqneg_reg[l] <= n[NUMS_WIDTH-1] ^ ctx_in.aneg;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            nv_reg <= 1'b0;
        else if (en)
            nv_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (en)
            nctx_reg <= ctx_in;
    end

    for (genvar k = 0; k < QUO_WIDTH; k++)
    begin : g_stage
        logic v_prev;
        ctx_t c_prev;
        logic [DIV_REM_WIDTH:0] dvs;

        if (k == 0)
        begin : g_first
            assign v_prev = nv_reg;
            assign c_prev = nctx_reg;
        end
        else
        begin : g_next
            assign v_prev = v_reg[k-1];
            assign c_prev = ctx_reg[k-1];
        end

        assign dvs = {1'b0, c_prev.amag, 1'b0};

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                v_reg[k] <= 1'b0;
            else if (en)
                v_reg[k] <= v_prev;
        end

        always_ff @(posedge clk)
        begin
            if (en)
                ctx_reg[k] <= c_prev;
        end

        for (genvar l = 0; l < LANES; l++)
        begin : g_lane
            logic [QUO_WIDTH-1:0]     num_prev, quo_prev;
            logic [DIV_REM_WIDTH-1:0] rem_prev;
            logic                     qn_prev;
            logic [DIV_REM_WIDTH:0]   rs;
            logic                     ge;

            if (k == 0)
            begin : g_first
                assign num_prev = nnum_reg[l];
                assign quo_prev = '0;
                assign rem_prev = '0;
                assign qn_prev  = nqneg_reg[l];
            end
            else
            begin : g_next
                assign num_prev = num_reg[l][k-1];
                assign quo_prev = quo_reg[l][k-1];
                assign rem_prev = rem_reg[l][k-1];
                assign qn_prev  = qneg_reg[l][k-1];
            end

            // shift in the next dividend bit, subtract the divisor if it fits
            assign rs = {rem_prev, num_prev[QUO_WIDTH-1]};
            assign ge = (rs >= dvs);

            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    num_reg[l][k]  <= num_prev << 1;
                    rem_reg[l][k]  <= ge ? DIV_REM_WIDTH'(rs - dvs) : DIV_REM_WIDTH'(rs);
                    quo_reg[l][k]  <= {quo_prev[QUO_WIDTH-2:0], ge};
                    qneg_reg[l][k] <= qn_prev;
                end
            end
        end
    end

    assign valid = v_reg[QUO_WIDTH-1];
    assign ctx   = ctx_reg[QUO_WIDTH-1];

    for (genvar l = 0; l < LANES; l++)
    begin : g_out
        assign qneg[l] = qneg_reg[l][QUO_WIDTH-1];
        assign quo[l]  = quo_reg[l][QUO_WIDTH-1];
    end

endmodule

/* hw/rtl/quadratic_root_solver.sv */
// Quadratic root solver top level: discriminant, square root, division, saturation.
// Coefficients are 32-bit Q16.16.
// Throughput: one item per cycle; the whole pipeline advances together, so a stall
//   at the output holds every stage and in_stall follows out_valid && out_stall.
// Reset: asynchronous, active low; clears all stage valid bits and the output valid.
//   Payload registers are not reset.
module quadratic_root_solver (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   in_valid,
    output logic                                   in_stall,
    input  logic signed [qrs_pkg::COEF_WIDTH-1:0]  coef_a,
    input  logic signed [qrs_pkg::COEF_WIDTH-1:0]  coef_b,
    input  logic signed [qrs_pkg::COEF_WIDTH-1:0]  coef_c,
    output logic                                   out_valid,
    input  logic                                   out_stall,
    output logic [1:0]                             root_kind,
    output logic signed [qrs_pkg::COEF_WIDTH-1:0]  root_plus,
    output logic signed [qrs_pkg::COEF_WIDTH-1:0]  root_minus,
    output logic                                   overflow
);
    import qrs_pkg::*;

    logic                  en;
    logic                  d_valid, s_valid, q_valid;
    ctx_t                  d_ctx, s_ctx, q_ctx;
    logic [DISC_WIDTH-1:0] d_disc;
    logic [ROOT_WIDTH-1:0] s_root;
    logic                  q_neg [LANES];
    logic [QUO_WIDTH-1:0]  q_quo [LANES];

    logic [COEF_WIDTH-1:0] lane_res [LANES];
    logic                  lane_ovf [LANES];

    logic                  out_valid_reg;
    kind_t                 kind_reg, kind_next;
    logic [COEF_WIDTH-1:0] plus_reg, plus_next, minus_reg, minus_next;
    logic                  ovf_reg, ovf_next;

    // advance every stage unless a finished item waits at the output
    assign en       = !out_valid_reg || !out_stall;
    assign in_stall = !en;

    qrs_disc u_disc (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (en),
        .in_valid (in_valid),
        .coef_a   (coef_a),
        .coef_b   (coef_b),
        .coef_c   (coef_c),
        .valid    (d_valid),
        .ctx      (d_ctx),
        .disc     (d_disc)
    );

    qrs_sqrt u_sqrt (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (en),
        .in_valid (d_valid),
        .ctx_in   (d_ctx),
        .disc_in  (d_disc),
        .valid    (s_valid),
        .ctx      (s_ctx),
        .root     (s_root)
    );

    qrs_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (en),
        .in_valid (s_valid),
        .ctx_in   (s_ctx),
        .root_in  (s_root),
        .valid    (q_valid),
        .ctx      (q_ctx),
        .qneg     (q_neg),
        .quo      (q_quo)
    );

    // saturate each quotient to the signed coefficient range, then apply the sign
    for (genvar l = 0; l < LANES; l++)
    begin : g_sat
        logic [QUO_WIDTH-1:0]  lim;
        logic [COEF_WIDTH-1:0] mag;

        assign lim = QUO_WIDTH'(q_neg[l] ? ROOT_MIN : ROOT_MAX);
        assign lane_ovf[l] = (q_quo[l] > lim);
        assign mag = lane_ovf[l] ? lim[COEF_WIDTH-1:0] : q_quo[l][COEF_WIDTH-1:0];
        assign lane_res[l] = q_neg[l] ? (-mag) : mag;
    end

    // zero the roots that the kind does not report
    always_comb
    begin
        kind_next  = q_ctx.kind;
        plus_next  = '0;
        minus_next = '0;
        ovf_next   = 1'b0;
        case (q_ctx.kind)
            KIND_DOUBLE:
            begin
                plus_next = lane_res[LANE_PLUS];
                ovf_next  = lane_ovf[LANE_PLUS];
            end
            KIND_TWO:
            begin
                plus_next  = lane_res[LANE_PLUS];
                minus_next = lane_res[LANE_MINUS];
                ovf_next   = lane_ovf[LANE_PLUS] || lane_ovf[LANE_MINUS];
            end
            default:
            begin
                plus_next  = '0;
                minus_next = '0;
                ovf_next   = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (en)
            out_valid_reg <= q_valid;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            kind_reg  <= kind_next;
            plus_reg  <= plus_next;
            minus_reg <= minus_next;
            ovf_reg   <= ovf_next;
        end
    end

    assign out_valid  = out_valid_reg;
    assign root_kind  = kind_reg;
    assign root_plus  = $signed(plus_reg);
    assign root_minus = $signed(minus_reg);
    assign overflow   = ovf_reg;

    a_minus_only_two : assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && root_kind != KIND_TWO |-> root_minus == '0)
        else $error("minus root set without two roots");

    a_no_root_zero : assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (root_kind == KIND_NOT_QUAD || root_kind == KIND_NO_REAL)
        |-> root_plus == '0 && !overflow)
        else $error("root or overflow set with no real root");

    a_ovf_at_limit : assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && overflow |-> (root_plus == ROOT_MAX || root_plus == ROOT_MIN
        || root_minus == ROOT_MAX || root_minus == ROOT_MIN))
        else $error("overflow flagged without a saturated root");

    a_stall_holds : assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |-> in_stall)
        else $error("input taken while output held");

endmodule
